/* rtl/core/sorted_list_engine_top_assert.svh */
// Assertion macros shared by the sorted list engine RTL.
`ifndef SORTED_LIST_ENGINE_TOP_ASSERT_SVH
`define SORTED_LIST_ENGINE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked check, held off while reset is asserted
`define SLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define SLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define SLE_ASSERT(lbl, prop, msg)

`define SLE_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* rtl/core/sle_pkg.sv */
// Shared types and constants of the sorted list engine.
package sle_pkg;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int VALUE_W          = 32;
  localparam int OP_W             = 2;
  localparam int POS_W            = 6;
  localparam int STATUS_W         = 2;
  localparam int COUNT_OUT_W      = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 2'd0,
    OP_TAKE_FIRST = 2'd1,
    OP_TAKE_LAST  = 2'd2,
    OP_TAKE_INDEX = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic                      ins_en;
    logic                      rem_en;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

endpackage

/* rtl/core/sle_if.sv */
// Request and response channel interfaces of the sorted list engine.
interface sle_req_if import sle_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink (input valid, input operation, input value, input position,
                output ready);
endinterface

interface sle_rsp_if import sle_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] removed_value;
  logic [STATUS_W-1:0]       status;
  logic [COUNT_OUT_W-1:0]    entry_count;

  modport source (output valid, output removed_value, output status,
                  output entry_count, input ready);
  modport sink (input valid, input removed_value, input status, input entry_count,
                output ready);
endinterface

/* rtl/core/sorted_list_engine_top.sv */
// Top level of the sorted list engine: control, result register and cell chain.
//
//  channel | dir | handshake     | payload
//  req_i   | in  | valid / ready | operation, value, position
//  rsp_o   | out | valid / ready | removed_value, status, entry_count
//
// The whole chain of cells shifts in the accepting cycle and the result is
// registered for the next one, so items may arrive back to back while results
// are taken. The removed value comes from a select over all cells by index.
// Reset clears the entry count and the result valid flag; cells hold no reset.
// A stalled result blocks new items only while it waits in the result register.
module sorted_list_engine_top import sle_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  sle_req_if.sink   req_i,
  sle_rsp_if.source rsp_o
);

`include "sorted_list_engine_top_assert.svh"

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]             count_q, count_d;
  logic                      rsp_valid_q;
  logic signed [VALUE_W-1:0] rsp_value_q;
  status_e                   rsp_status_q;
  logic [COUNT_OUT_W-1:0]    rsp_count_q;

  logic                      accept;
  op_e                       op;
  logic                      empty, full;
  logic [CMPW-1:0]           count_ext, pos_ext, rem_idx;
  status_e                   status;
  cmd_t                      cmd;
  logic signed [VALUE_W-1:0] sel_value;

  logic signed [VALUE_W-1:0] entry_w [CAPACITY];
  logic                      lt_w    [CAPACITY];

  // handshake
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // decode
  assign op        = op_e'(req_i.operation);
  assign empty     = (count_q == '0);
  assign full      = (count_q == CW'(CAPACITY));
  assign count_ext = CMPW'(count_q);
  assign pos_ext   = CMPW'(req_i.position);

  always_comb begin
    status  = ST_OK;
    rem_idx = '0;
    unique case (op)
      OP_INSERT: begin
        if (full) status = ST_FULL;
      end
      OP_TAKE_FIRST: begin
        if (empty) status = ST_EMPTY;
      end
      OP_TAKE_LAST: begin
        rem_idx = count_ext - CMPW'(1);
        if (empty) status = ST_EMPTY;
      end
      OP_TAKE_INDEX: begin
        rem_idx = pos_ext;
        if (empty) begin
          status = ST_EMPTY;
        end else if (pos_ext >= count_ext) begin
          status = ST_RANGE;
        end
      end
      default: status = ST_OK;
    endcase
  end

  assign cmd.ins_en = accept && (op == OP_INSERT) && (status == ST_OK);
  assign cmd.rem_en = accept && (op != OP_INSERT) && (status == ST_OK);
  assign cmd.value  = req_i.value;

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_entry, right_entry;
    logic                      left_lt;

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_lt    = 1'b0;
    end else begin : g_body
      assign left_entry = entry_w[i-1];
      assign left_lt    = lt_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = entry_w[i];
    end else begin : g_inner
      assign right_entry = entry_w[i+1];
    end

    sle_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .in_range_i    (CW'(i) < count_q),
      .at_count_i    (CW'(i) == count_q),
      .from_pos_i    (CMPW'(i) >= rem_idx),
      .left_entry_i  (left_entry),
      .left_lt_i     (left_lt),
      .right_entry_i (right_entry),
      .entry_o       (entry_w[i]),
      .lt_o          (lt_w[i])
    );
  end

  // pick the entry being removed
  always_comb begin
    sel_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CMPW'(i) == rem_idx) sel_value = sel_value | entry_w[i];
    end
  end

  // entry count
  always_comb begin
    count_d = count_q;
    if (cmd.ins_en) begin
      count_d = count_q + CW'(1);
    end else if (cmd.rem_en) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_value_q  <= cmd.rem_en ? sel_value : '0;
      rsp_status_q <= status;
      rsp_count_q  <= COUNT_OUT_W'(count_d);
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.removed_value = rsp_value_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.entry_count   = rsp_count_q;

  // checks
  `SLE_ASSERT_ALWAYS(a_count_bound, !rst_ni || count_q <= CW'(CAPACITY), "entry count above capacity")
  `SLE_ASSERT(a_ins_count, cmd.ins_en |=> count_q == CW'($past(count_q) + CW'(1)), "insert count")
  `SLE_ASSERT(a_rem_count, cmd.rem_en |=> count_q == CW'($past(count_q) - CW'(1)), "remove count")
  `SLE_ASSERT(a_idle_count, !accept |=> $stable(count_q), "count moved without an item")

endmodule

/* rtl/core/sle_cell.sv */
// One slot of the sorted list: holds an entry and shifts with its neighbors.
module sle_cell import sle_pkg::*; (
  input  logic                      clk_i,
  input  cmd_t                      cmd_i,
  input  logic                      in_range_i,   // slot holds a valid entry
  input  logic                      at_count_i,   // first free slot
  input  logic                      from_pos_i,   // slot at or after removal point
  input  logic signed [VALUE_W-1:0] left_entry_i,
  input  logic                      left_lt_i,
  input  logic signed [VALUE_W-1:0] right_entry_i,
  output logic signed [VALUE_W-1:0] entry_o,
  output logic                      lt_o
);

  logic signed [VALUE_W-1:0] entry_q, entry_d;

  // new value sorts before this entry
  assign lt_o = in_range_i && (cmd_i.value < entry_q);

  // shift right on insert, shift left on removal
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins_en) begin
      if (left_lt_i) begin
        entry_d = left_entry_i;
      end else if (lt_o || at_count_i) begin
        entry_d = cmd_i.value;
      end
    end else if (cmd_i.rem_en && from_pos_i) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the sorted list engine: directed table, random episodes, predictor.
module testbench;
  import sle_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = DEFAULT_CAPACITY;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 20;
  localparam int MAX_PRINTS  = 40;
  localparam logic signed [VALUE_W-1:0] JUNK_VAL = 32'sh5A5A_A5A5;
  localparam logic signed [VALUE_W-1:0] VAL_MIN  = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;

  // One list operation, with an optional hand-written result
  typedef struct {
    op_e                       op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    bit                        typed;
    logic signed [VALUE_W-1:0] exp_removed;
    status_e                   exp_status;
    logic [COUNT_OUT_W-1:0]    exp_count;
  } list_cmd_t;

  typedef struct {
    logic signed [VALUE_W-1:0] removed;
    status_e                   status;
    logic [COUNT_OUT_W-1:0]    count;
  } list_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sle_req_if req_if ();
  sle_rsp_if rsp_if ();

  sorted_list_engine_top #(.CAPACITY(DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  // Mirror of the list contents
  logic signed [VALUE_W-1:0] mirror_entries [DEPTH];
  int                        mirror_count = 0;

  list_cmd_t op_backlog [$];
  list_rsp_t due_results [$];
  list_cmd_t offered_cmd;
  list_rsp_t predicted;
  list_rsp_t rsp_want;
  bit        offer_next;

  int plan_count     = 0;
  int pushed_total   = 0;
  int accepted_total = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asks      = 0;
  int hold_taken     = 0;
  int hold_left      = 0;
  int cycles         = 0;
  int errors         = 0;
  int n_insert = 0, n_remove = 0, n_full = 0, n_empty = 0, n_range = 0, n_checked = 0;

  // Directed rows: empty-list removals, extremes, duplicates, index at and past the count
  list_cmd_t dir_rows [22] = '{
    '{OP_TAKE_FIRST, JUNK_VAL, 6'h3F, 1'b1, '0, ST_EMPTY, 7'd0},
    '{OP_TAKE_LAST,  JUNK_VAL, 6'h3F, 1'b1, '0, ST_EMPTY, 7'd0},
    '{OP_TAKE_INDEX, JUNK_VAL, 6'd0,  1'b1, '0, ST_EMPTY, 7'd0},
    '{OP_TAKE_INDEX, JUNK_VAL, 6'h3F, 1'b1, '0, ST_EMPTY, 7'd0},
    '{OP_INSERT,     VAL_MAX,  6'h3F, 1'b1, '0, ST_OK,    7'd1},
    '{OP_INSERT,     VAL_MIN,  6'h2A, 1'b1, '0, ST_OK,    7'd2},
    '{OP_INSERT,     32'sd0,   6'h15, 1'b1, '0, ST_OK,    7'd3},
    '{OP_INSERT,     -32'sd1,  6'd0,  1'b1, '0, ST_OK,    7'd4},
    '{OP_INSERT,     32'sd1,   6'd0,  1'b0, '0, ST_OK,    7'd0},
    '{OP_INSERT,     32'sd1,   6'h3F, 1'b0, '0, ST_OK,    7'd0},
    '{OP_TAKE_INDEX, JUNK_VAL, 6'd6,  1'b1, '0, ST_RANGE, 7'd6},
    '{OP_TAKE_INDEX, JUNK_VAL, 6'h3F, 1'b1, '0, ST_RANGE, 7'd6},
    '{OP_TAKE_FIRST, JUNK_VAL, 6'h3F, 1'b1, VAL_MIN, ST_OK, 7'd5},
    '{OP_TAKE_LAST,  JUNK_VAL, 6'h2A, 1'b1, VAL_MAX, ST_OK, 7'd4},
    '{OP_TAKE_INDEX, JUNK_VAL, 6'd1,  1'b1, 32'sd0,  ST_OK, 7'd3},
    '{OP_TAKE_INDEX, JUNK_VAL, 6'd2,  1'b1, 32'sd1,  ST_OK, 7'd2},
    '{OP_TAKE_INDEX, JUNK_VAL, 6'd0,  1'b1, -32'sd1, ST_OK, 7'd1},
    '{OP_TAKE_LAST,  JUNK_VAL, 6'd0,  1'b1, 32'sd1,  ST_OK, 7'd0},
    '{OP_TAKE_LAST,  JUNK_VAL, 6'd0,  1'b1, '0, ST_EMPTY, 7'd0},
    '{OP_INSERT,     -32'sd5,  6'd9,  1'b1, '0, ST_OK,    7'd1},
    '{OP_TAKE_INDEX, JUNK_VAL, 6'd1,  1'b1, '0, ST_RANGE, 7'd1},
    '{OP_TAKE_INDEX, JUNK_VAL, 6'd0,  1'b1, -32'sd5, ST_OK, 7'd0}
  };

  // Apply one operation to the mirror list and return its result
  function automatic list_rsp_t sorted_list_apply(op_e op, logic signed [VALUE_W-1:0] val,
                                                  logic [POS_W-1:0] pos);
    list_rsp_t r;
    int        i;
    r.removed = '0;
    r.status  = ST_OK;
    if (op == OP_INSERT) begin
      if (mirror_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        i = mirror_count;
        while (i > 0 && val < mirror_entries[i-1]) begin
          mirror_entries[i] = mirror_entries[i-1];
          i--;
        end
        mirror_entries[i] = val;
        mirror_count++;
      end
    end else if (mirror_count == 0) begin
      r.status = ST_EMPTY;
    end else if (op == OP_TAKE_INDEX && int'(pos) >= mirror_count) begin
      r.status = ST_RANGE;
    end else begin
      if (op == OP_TAKE_FIRST) i = 0;
      else if (op == OP_TAKE_LAST) i = mirror_count - 1;
      else i = int'(pos);
      r.removed = mirror_entries[i];
      while (i < mirror_count - 1) begin
        mirror_entries[i] = mirror_entries[i+1];
        i++;
      end
      mirror_count--;
    end
    r.count = COUNT_OUT_W'(mirror_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("MISMATCH @%0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  // Queue an item and track the count it leaves, so episodes can aim at full or empty
  task automatic add_item(list_cmd_t c);
    if (c.op == OP_INSERT) begin
      if (plan_count < DEPTH) plan_count++;
    end else if (plan_count > 0 && !(c.op == OP_TAKE_INDEX && int'(c.position) >= plan_count)) begin
      plan_count--;
    end
    op_backlog.push_back(c);
    pushed_total++;
  endtask

  function automatic list_cmd_t make_cmd(op_e op);
    list_cmd_t c;
    c.op    = op;
    c.typed = 1'b0;
    c.exp_removed = '0;
    c.exp_status  = ST_OK;
    c.exp_count   = '0;
    // Extremes, a narrow band that makes duplicates, or anything
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: c.value = VAL_MIN;
          1: c.value = VAL_MAX;
          2: c.value = 32'sd0;
          default: c.value = -32'sd1;
        endcase
      end
      1, 2, 3: c.value = $signed($urandom_range(0, 15)) - 32'sd8;
      default: c.value = $urandom;
    endcase
    if (plan_count > 0 && $urandom_range(0, 9) < 8)
      c.position = POS_W'($urandom_range(0, plan_count - 1));
    else
      c.position = POS_W'($urandom_range(0, 63));
    return c;
  endfunction

  // Random episodes: fill to full, drain to empty, or a mixed walk
  task automatic queue_random(int n);
    int goal;
    int kind;
    goal = pushed_total + n;
    while (pushed_total < goal) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        while (plan_count < DEPTH) add_item(make_cmd(OP_INSERT));
        repeat ($urandom_range(1, 3)) add_item(make_cmd(OP_INSERT));
      end else if (kind == 1) begin
        while (plan_count > 0) add_item(make_cmd(op_e'($urandom_range(1, 3))));
        repeat ($urandom_range(1, 3)) add_item(make_cmd(op_e'($urandom_range(1, 3))));
      end else begin
        repeat ($urandom_range(10, 40)) begin
          if ($urandom_range(0, 99) < 55) add_item(make_cmd(OP_INSERT));
          else add_item(make_cmd(op_e'($urandom_range(1, 3))));
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (accepted_total != pushed_total || due_results.size() != 0) @(posedge clk_i);
  endtask

  // Request side: hold valid until accepted, predict on acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      offer_next = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        predicted = sorted_list_apply(offered_cmd.op, offered_cmd.value, offered_cmd.position);
        if (offered_cmd.typed)
          due_results.push_back('{offered_cmd.exp_removed, offered_cmd.exp_status,
                                   offered_cmd.exp_count});
        else
          due_results.push_back(predicted);
        accepted_total++;
        if (offered_cmd.op == OP_INSERT) n_insert++;
        else n_remove++;
        case (predicted.status)
          ST_FULL:  n_full++;
          ST_EMPTY: n_empty++;
          ST_RANGE: n_range++;
          default: ;
        endcase
        offer_next = 1'b0;
      end
      if (!offer_next && op_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        offered_cmd = op_backlog.pop_front();
        offer_next  = 1'b1;
      end
      req_if.valid     <= offer_next;
      req_if.operation <= offered_cmd.op;
      req_if.value     <= offered_cmd.value;
      req_if.position  <= offered_cmd.position;
    end
  end

  // Response side: random stalls plus long hold-offs on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (hold_asks != hold_taken) begin
        hold_taken++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Result check against the oldest outstanding result
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with none outstanding, status", 32'(rsp_if.status), '0);
      end else begin
        rsp_want = due_results.pop_front();
        n_checked++;
        if (rsp_if.removed_value !== rsp_want.removed)
          report_mismatch("removed_value", rsp_if.removed_value, rsp_want.removed);
        if (rsp_if.status !== rsp_want.status)
          report_mismatch("status", 32'(rsp_if.status), 32'(rsp_want.status));
        if (rsp_if.entry_count !== rsp_want.count)
          report_mismatch("entry_count", 32'(rsp_if.entry_count), 32'(rsp_want.count));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding", cycles, due_results.size());
      $display("** sorted_list_engine_top: FAILED **");
      $finish;
    end
  end

  initial begin
    req_if.valid     = 1'b0;
    req_if.operation = OP_INSERT;
    req_if.value     = '0;
    req_if.position  = '0;
    rsp_if.ready     = 1'b0;
    offered_cmd      = dir_rows[0];
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, no idling
    foreach (dir_rows[k]) add_item(dir_rows[k]);
    wait_drained();

    // Random phases under different idle patterns
    send_idle_pct = 0;  recv_stall_pct = 0;  queue_random(300); wait_drained();
    send_idle_pct = 82; recv_stall_pct = 0;  queue_random(300); wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 82; queue_random(300); wait_drained();
    send_idle_pct = 26; recv_stall_pct = 26; queue_random(300); wait_drained();

    // Long receiver hold-off while items keep coming, then a full pause and more items
    send_idle_pct = 0; recv_stall_pct = 10;
    hold_asks++;
    queue_random(100);
    wait_drained();
    queue_random(50);
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Checked %0d results from %0d items: %0d inserts, %0d removals.",
             n_checked, accepted_total, n_insert, n_remove);
    $display("Inserts into a full list %0d, removals from empty %0d, index past count %0d.",
             n_full, n_empty, n_range);
    if (errors == 0) begin
      $display("** sorted_list_engine_top: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** sorted_list_engine_top: FAILED **");
    end
    $finish;
  end

endmodule
